// ===== hdl/pmffa_pkg.sv =====
// Shared types, constants and the control program of the page map allocator.
package pmffa_pkg;

  localparam int MAX_PAGES_DEF = 4096;
  localparam int CFG_W = 14;
  localparam int CFG_IDX_W = 3;
  localparam int COUNT_OUT_W = 13;
  localparam int NEED_W = 20;
  localparam int PAGE_SHIFT = 12;

  localparam logic [31:0] PAGE_ROUND = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  localparam int LOW_HOLE_LAST = (1024 * 1024 - 1) / 4096;
  localparam int ISA_HOLE_FIRST = (15 * 1024 * 1024) / 4096;
  localparam int ISA_HOLE_LAST = (16 * 1024 * 1024 - 1) / 4096;
  localparam int BASE_KB = 1024;

  localparam logic [9:0] LOWMEM_RST = 10'd640;
  localparam logic [13:0] HIGHMEM_RST = 14'd15360;
  localparam logic [11:0] KFIRST_RST = 12'd256;
  localparam logic [11:0] KLAST_RST = 12'd300;
  localparam logic [11:0] MFIRST_RST = 12'd301;

  typedef enum logic [2:0] {
    PG_EMPTY      = 3'd0,
    PG_RESERVED   = 3'd1,
    PG_USED       = 3'd2,
    PG_MULTI      = 3'd3,
    PG_MULTI_LAST = 3'd4,
    PG_KERNEL     = 3'd5
  } page_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWMEM  = 3'd0,
    REG_HIGHMEM = 3'd1,
    REG_KFIRST  = 3'd2,
    REG_KLAST   = 3'd3,
    REG_MFIRST  = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    FUNC_BUILD = 1'b0,
    FUNC_ALLOC = 1'b1
  } func_t;

  typedef struct packed {
    logic        func;
    logic [31:0] size_bytes;
  } req_t;

  typedef struct packed {
    logic                   status;
    logic [31:0]            address;
    logic [COUNT_OUT_W-1:0] free_pages;
    logic [COUNT_OUT_W-1:0] total_pages;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'd0,
    S_DISP  = 4'd1,
    S_BLOOP = 4'd2,
    S_PRIME = 4'd3,
    S_SCAN  = 4'd4,
    S_SORT  = 4'd5,
    S_MARK  = 4'd6,
    S_MLAST = 4'd7,
    S_DONE  = 4'd8,
    S_FAIL  = 4'd9
  } step_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_NO_REQ,
    C_ALLOC,
    C_IDX_END,
    C_SCAN_EXIT,
    C_AT_END,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_BUILD_INIT,
    OP_BUILD_WRITE,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_MARK_INIT,
    OP_MARK_WRITE,
    OP_MARK_LAST,
    OP_SET_FAIL,
    OP_LOAD_OUT
  } op_t;

  // cond true: go to target, op skipped; else run op and go to nxt
  typedef struct packed {
    cond_t cond;
    step_t target;
    op_t   op;
    step_t nxt;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      S_IDLE:  w = '{C_NO_REQ,    S_IDLE,  OP_LATCH,       S_DISP};
      S_DISP:  w = '{C_ALLOC,     S_PRIME, OP_BUILD_INIT,  S_BLOOP};
      S_BLOOP: w = '{C_IDX_END,   S_DONE,  OP_BUILD_WRITE, S_BLOOP};
      S_PRIME: w = '{C_NEVER,     S_IDLE,  OP_SCAN_INIT,   S_SCAN};
      S_SCAN:  w = '{C_SCAN_EXIT, S_SORT,  OP_SCAN_STEP,   S_SCAN};
      S_SORT:  w = '{C_IDX_END,   S_FAIL,  OP_MARK_INIT,   S_MARK};
      S_MARK:  w = '{C_AT_END,    S_MLAST, OP_MARK_WRITE,  S_MARK};
      S_MLAST: w = '{C_NEVER,     S_IDLE,  OP_MARK_LAST,   S_DONE};
      S_DONE:  w = '{C_OUT_BUSY,  S_DONE,  OP_LOAD_OUT,    S_IDLE};
      S_FAIL:  w = '{C_NEVER,     S_IDLE,  OP_SET_FAIL,    S_DONE};
      default: w = '{C_NEVER,     S_IDLE,  OP_NOP,         S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/page_map_first_fit_allocator.sv =====
// Top level: microcoded first-fit page frame allocator over a 3-bit page map.
//
// The single page map memory handles one page per cycle in the scan, the
// build sweep and the marking of the found run.
// A request is taken only while the sequencer is idle; a finished result may
// still wait in the output register meanwhile. The map needs no clearing after
// reset: only values read for pages below the current page count are used, and
// a build writes all of them. Configuration writes are taken in every cycle.
module page_map_first_fit_allocator #(
  parameter int MAX_PAGES = pmffa_pkg::MAX_PAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  pmffa_pkg::req_t                  req_data,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output pmffa_pkg::rsp_t                  rsp_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pmffa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmffa_pkg::CFG_W-1:0]      cfg_data
);
  import pmffa_pkg::*;

  localparam int PW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int NW = (CW > 13) ? CW : 13;
  localparam int RW = (CW > NEED_W) ? CW : NEED_W;

  logic [9:0]  lowmem_kb;
  logic [13:0] highmem_kb;
  logic [11:0] kernel_first_page;
  logic [11:0] kernel_last_page;
  logic [11:0] map_first_page;

  step_t pc;
  step_t pc_next;
  ctrl_t cw;
  logic  cond_true;
  logic  do_op;

  logic [CW-1:0]     idx;
  logic [CW-1:0]     run;
  logic [PW-1:0]     start;
  logic [PW-1:0]     end_page;
  logic [NEED_W-1:0] need;
  logic              func;
  logic [CW-1:0]     map_pages;
  logic [CW-1:0]     free_count;
  logic              status;
  logic [31:0]       address;

  logic [2:0]  page_map [MAX_PAGES];
  logic [2:0]  rdata;
  logic        mem_we;
  logic [2:0]  mem_wdata;
  logic        mem_re;
  logic [PW-1:0] mem_raddr;

  logic [31:0]       rounded;
  logic [NEED_W-1:0] need_raw;
  logic [NW-1:0]     n_raw;
  logic [CW-1:0]     n_sat;
  logic [NW-1:0]     i_w;
  logic [NW-1:0]     map_last;
  page_state_t       build_state;
  logic              idx_end;
  logic              hit;
  logic              out_busy;

  assign cfg_ready = 1'b1;
  assign req_ready = (pc == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      lowmem_kb         <= LOWMEM_RST;
      highmem_kb        <= HIGHMEM_RST;
      kernel_first_page <= KFIRST_RST;
      kernel_last_page  <= KLAST_RST;
      map_first_page    <= MFIRST_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWMEM:  lowmem_kb         <= cfg_data[9:0];
        REG_HIGHMEM: highmem_kb        <= cfg_data[13:0];
        REG_KFIRST:  kernel_first_page <= cfg_data[11:0];
        REG_KLAST:   kernel_last_page  <= cfg_data[11:0];
        REG_MFIRST:  map_first_page    <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rounded  = (req_data.size_bytes + PAGE_ROUND) & PAGE_MASK;
    need_raw = rounded[31:PAGE_SHIFT];
    if (need_raw == '0) begin
      need_raw = NEED_W'(1);
    end
  end

  always_comb begin
    n_raw = NW'((15'(highmem_kb) + 15'(BASE_KB)) >> 2);
    if (n_raw > NW'(MAX_PAGES)) begin
      n_sat = CW'(MAX_PAGES);
    end else begin
      n_sat = CW'(n_raw);
    end
  end

  always_comb begin
    i_w      = NW'(idx);
    map_last = NW'(map_first_page) + NW'(map_pages >> PAGE_SHIFT);
    if (i_w == '0) begin
      build_state = PG_RESERVED;
    end else if (NW'(kernel_first_page) <= i_w && i_w <= NW'(kernel_last_page)) begin
      build_state = PG_KERNEL;
    end else if (NW'(map_first_page) <= i_w && i_w <= map_last) begin
      build_state = PG_KERNEL;
    end else if (NW'(lowmem_kb[9:2]) <= i_w && i_w <= NW'(LOW_HOLE_LAST)) begin
      build_state = PG_RESERVED;
    end else if (NW'(ISA_HOLE_FIRST) <= i_w && i_w <= NW'(ISA_HOLE_LAST)) begin
      build_state = PG_RESERVED;
    end else begin
      build_state = PG_EMPTY;
    end
  end

  assign idx_end  = (idx == map_pages);
  assign hit      = !idx_end && (rdata == PG_EMPTY) && (RW'(run) + RW'(1) >= RW'(need));
  assign out_busy = rsp_valid && !rsp_ready;

  always_comb begin
    cw = ucode(pc);
    case (cw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_NO_REQ:    cond_true = !req_valid;
      C_ALLOC:     cond_true = (func == FUNC_ALLOC);
      C_IDX_END:   cond_true = idx_end;
      C_SCAN_EXIT: cond_true = idx_end || hit;
      C_AT_END:    cond_true = (idx[PW-1:0] == end_page);
      C_OUT_BUSY:  cond_true = out_busy;
      default:     cond_true = 1'b0;
    endcase
    do_op   = !cond_true;
    pc_next = cond_true ? cw.target : cw.nxt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = PG_EMPTY;
    mem_re    = 1'b0;
    mem_raddr = PW'(idx + CW'(1));
    if (do_op) begin
      case (cw.op)
        OP_BUILD_WRITE: begin
          mem_we    = 1'b1;
          mem_wdata = build_state;
        end
        OP_SCAN_INIT: begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
        OP_SCAN_STEP: begin
          mem_re = 1'b1;
        end
        OP_MARK_WRITE: begin
          mem_we    = 1'b1;
          mem_wdata = PG_MULTI;
        end
        OP_MARK_LAST: begin
          mem_we    = 1'b1;
          mem_wdata = PG_MULTI_LAST;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_map[idx[PW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= page_map[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_pages  <= '0;
      free_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (do_op && cw.op == OP_LOAD_OUT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (do_op) begin
        case (cw.op)
          OP_BUILD_INIT: begin
            map_pages  <= n_sat;
            free_count <= '0;
          end
          OP_BUILD_WRITE: begin
            if (build_state == PG_EMPTY) begin
              free_count <= free_count + CW'(1);
            end
          end
          OP_MARK_INIT: begin
            free_count <= free_count - CW'(need);
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_op) begin
      case (cw.op)
        OP_LATCH: begin
          func <= req_data.func;
          need <= need_raw;
        end
        OP_BUILD_INIT: begin
          idx     <= '0;
          status  <= 1'b0;
          address <= '0;
        end
        OP_BUILD_WRITE: begin
          idx <= idx + CW'(1);
        end
        OP_SCAN_INIT: begin
          idx     <= '0;
          run     <= '0;
          status  <= 1'b0;
          address <= '0;
        end
        OP_SCAN_STEP: begin
          if (rdata == PG_EMPTY) begin
            if (run == '0) begin
              start <= idx[PW-1:0];
            end
            run <= run + CW'(1);
          end else begin
            run <= '0;
          end
          idx <= idx + CW'(1);
        end
        OP_MARK_INIT: begin
          end_page <= idx[PW-1:0];
          if (run == '0) begin
            start <= idx[PW-1:0];
            idx   <= idx;
          end else begin
            idx <= CW'(start);
          end
        end
        OP_MARK_WRITE: begin
          idx <= idx + CW'(1);
        end
        OP_MARK_LAST: begin
          address <= 32'({start, {PAGE_SHIFT{1'b0}}});
        end
        OP_SET_FAIL: begin
          status  <= 1'b1;
          address <= '0;
        end
        OP_LOAD_OUT: begin
          rsp_data.status      <= status;
          rsp_data.address     <= address;
          rsp_data.free_pages  <= COUNT_OUT_W'(free_count);
          rsp_data.total_pages <= COUNT_OUT_W'(map_pages);
        end
        default: ;
      endcase
    end
  end

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(pc) == S_DONE)
    else $error("result raised outside the done step");

  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    free_count <= map_pages)
    else $error("free page count above map size");

  a_mark_in_map: assert property (@(posedge clk) disable iff (rst)
    (pc == S_MARK || pc == S_MLAST) |-> idx < map_pages)
    else $error("run marking outside the map");

  a_req_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> pc == S_DISP)
    else $error("accepted request did not start the program");

endmodule
